// File: rtl/core/bezier_curve_evaluator_macros.svh
// ----------------------------------------------------------------------------
// Bezier curve evaluator assertion macros
// Concurrent checks clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BEZIER_CURVE_EVALUATOR_MACROS_SVH
`define BEZIER_CURVE_EVALUATOR_MACROS_SVH

// same-cycle implication
`define BCE_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/bce_pkg.sv
// ----------------------------------------------------------------------------
// Bezier curve evaluator package
// Widths, constants, transfer types and the binomial table builder.
// ----------------------------------------------------------------------------
package bce_pkg;

  localparam int MAX_POINTS_DEF  = 7;
  localparam int COORD_BITS_DEF  = 16;
  localparam int MAX_POINTS_HI   = 16;

  localparam int COORD_W = 16;
  localparam int PIDX_W  = 3;
  localparam int U_W     = 17;
  localparam int CFG_W   = 3;
  localparam int DEG_W   = 4;
  localparam int OUT_W   = 24;
  localparam int POW_W   = 31;
  localparam int WGT_W   = 32;
  localparam int BINOM_W = 13;
  localparam int ACC_W   = 64;
  localparam int OUT_SHIFT = 22;

  localparam logic [U_W-1:0]          U_ONE     = 17'h10000;
  localparam logic [POW_W-1:0]        POW_ONE   = 31'h4000_0000;
  localparam logic [CFG_W-1:0]        DEG_RESET = 3'd6;
  localparam logic signed [ACC_W-1:0] OUT_RND   = 64'sd2097152;
  localparam logic signed [ACC_W-1:0] SAT_HI    = 64'sd8388607;
  localparam logic signed [ACC_W-1:0] SAT_LO    = -64'sd8388608;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } bce_cmd_t;

  typedef struct packed {
    bce_cmd_t                    cmd;
    logic [PIDX_W-1:0]           point_index;
    logic signed [COORD_W-1:0]   coord_x;
    logic signed [COORD_W-1:0]   coord_y;
    logic signed [COORD_W-1:0]   coord_z;
    logic [U_W-1:0]              param_u;
  } bce_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] curve_x;
    logic signed [OUT_W-1:0] curve_y;
    logic signed [OUT_W-1:0] curve_z;
  } bce_out_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic [U_W-1:0]     u;
    logic [U_W-1:0]     v;
    logic [DEG_W-1:0]   deg;
    logic               wr;
    logic [PIDX_W-1:0]  wr_idx;
    logic [COORD_W-1:0] wr_x;
    logic [COORD_W-1:0] wr_y;
    logic [COORD_W-1:0] wr_z;
  } bce_ctl_t;

  // Pascal triangle, elaboration only
  function automatic int binom_f(input int n, input int k);
    int row [MAX_POINTS_HI+1];
    for (int j = 0; j <= MAX_POINTS_HI; j++) row[j] = 0;
    row[0] = 1;
    for (int r = 1; r <= n; r++) begin
      for (int j = MAX_POINTS_HI; j >= 1; j--) row[j] = row[j] + row[j-1];
    end
    if (k < 0 || k > MAX_POINTS_HI) return 0;
    return row[k];
  endfunction

endpackage

// File: rtl/core/bce_cell.sv
// ----------------------------------------------------------------------------
// Bezier curve evaluator cell
// Holds one control point; forms its power of u from the left neighbor, its
// power of 1-u from the right neighbor, its Bernstein weight, and adds its
// weighted point into the partial sums moving to the right.
// ----------------------------------------------------------------------------
module bce_cell #(
  parameter int COORD_BITS = bce_pkg::COORD_BITS_DEF,
  parameter int IDX        = 0
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bce_pkg::bce_ctl_t                 ctl,
  input  logic [bce_pkg::POW_W-1:0]         a_in,
  input  logic [bce_pkg::POW_W-1:0]         b_in,
  input  logic signed [bce_pkg::ACC_W-1:0]  s_in [3],
  output logic [bce_pkg::POW_W-1:0]         a_out,
  output logic [bce_pkg::POW_W-1:0]         b_out,
  output logic signed [bce_pkg::ACC_W-1:0]  s_out [3]
);

  localparam int PW  = bce_pkg::POW_W;
  localparam int UW  = bce_pkg::U_W;
  localparam int AW  = bce_pkg::ACC_W;
  localparam int WW  = bce_pkg::WGT_W;
  localparam int BW  = bce_pkg::BINOM_W;
  localparam int CW  = bce_pkg::COORD_W;
  localparam int MW  = PW + UW;
  localparam int TW  = 2 * PW;
  localparam int KW  = BW + PW;
  localparam int PRW = WW + 1 + COORD_BITS;
  localparam int DN  = 2 ** bce_pkg::DEG_W;

  localparam logic [MW-1:0] PWR_RND = MW'(32768);
  localparam logic [TW-1:0] MUL_RND = TW'(32'h2000_0000);

  logic signed [COORD_BITS-1:0] pt_r    [3];
  logic signed [COORD_BITS-1:0] pt_nxt  [3];
  logic [CW-1:0]                coord_in [3];
  logic                         wr_hit;
  logic                         in_use;

  logic [BW-1:0]  coef_tab [DN];
  logic [BW-1:0]  coef;

  logic [MW-1:0]  a_mul, b_mul;
  logic [PW-1:0]  a_r, a_nxt, b_r, b_nxt;
  logic [TW-1:0]  t_mul;
  logic [PW-1:0]  t_r, t_nxt;
  logic [KW-1:0]  w_mul;
  logic [WW-1:0]  w_r, w_nxt;
  logic signed [WW:0]       w_s;
  logic signed [PRW-1:0]    prod_r   [3];
  logic signed [PRW-1:0]    prod_nxt [3];
  logic signed [AW-1:0]     s_r      [3];
  logic signed [AW-1:0]     s_nxt    [3];

  for (genvar n = 0; n < DN; n++) begin : g_coef
    assign coef_tab[n] = BW'(bce_pkg::binom_f(n, IDX));
  end

  assign coef   = coef_tab[ctl.deg];
  assign in_use = (32'(ctl.deg) >= IDX);
  assign wr_hit = ctl.wr && (32'(ctl.wr_idx) == IDX);

  assign coord_in[0] = ctl.wr_x;
  assign coord_in[1] = ctl.wr_y;
  assign coord_in[2] = ctl.wr_z;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      pt_nxt[c] = wr_hit ? COORD_BITS'({{(32-CW){1'b0}}, coord_in[c]}) : pt_r[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < 3; c++) pt_r[c] <= '0;
    end else begin
      pt_r <= pt_nxt;
    end
  end

  // powers of u ripple right, powers of 1-u ripple left from the degree cell
  assign a_mul = MW'(a_in) * MW'(ctl.u) + PWR_RND;
  assign b_mul = MW'(b_in) * MW'(ctl.v) + PWR_RND;
  assign a_nxt = (IDX == 0) ? bce_pkg::POW_ONE : a_mul[16 +: PW];
  assign b_nxt = (32'(ctl.deg) == IDX) ? bce_pkg::POW_ONE : b_mul[16 +: PW];

  assign t_mul = TW'(a_r) * TW'(b_r) + MUL_RND;
  assign t_nxt = t_mul[30 +: PW];

  assign w_mul = KW'(coef) * KW'(t_r);
  assign w_nxt = w_mul[WW-1:0];
  assign w_s   = signed'({1'b0, w_r});

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod_nxt[c] = in_use ? (PRW'(w_s) * PRW'(pt_r[c])) : '0;
      s_nxt[c]    = s_in[c] + AW'(prod_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    t_r    <= t_nxt;
    w_r    <= w_nxt;
    prod_r <= prod_nxt;
    s_r    <= s_nxt;
  end

  assign a_out = a_r;
  assign b_out = b_r;
  assign s_out = s_r;

endmodule

// File: rtl/core/bezier_curve_evaluator.sv
// ----------------------------------------------------------------------------
// Bezier curve evaluator
// A load transfer writes one control point. An evaluate transfer runs until its
// point sits in the output register, and no new item is taken while it runs;
// it waits at its end while an earlier result has not yet been taken.
// Its run is set by the row of point cells: powers of u and of 1-u travel
// one cell a cycle, each cell then forms its weight and product in three
// registered steps, and the partial sums travel one cell a cycle to the end
// of the row.
// A finished result may wait in the output register while new items are taken.
// ----------------------------------------------------------------------------
`include "bezier_curve_evaluator_macros.svh"

module bezier_curve_evaluator #(
  parameter int MAX_POINTS = bce_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = bce_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bce_pkg::bce_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bce_pkg::bce_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bce_pkg::CFG_W-1:0]     cfg_data
);

  localparam int PW       = bce_pkg::POW_W;
  localparam int AW       = bce_pkg::ACC_W;
  localparam int UW       = bce_pkg::U_W;
  localparam int DW       = bce_pkg::DEG_W;
  localparam int OW       = bce_pkg::OUT_W;
  localparam int DONE_CNT = 2 * MAX_POINTS + 3;
  localparam int CNT_W    = $clog2(DONE_CNT + 1);

  logic                       busy_r, busy_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [bce_pkg::CFG_W-1:0]  deg_cfg_r, deg_cfg_nxt;
  logic                       out_valid_r, out_valid_nxt;
  bce_pkg::bce_out_t          out_data_r;
  logic [UW-1:0]              u_r, v_r;
  logic [DW-1:0]              deg_r;

  logic                       in_xfer, eval_start, ld_point, finish;
  logic [UW-1:0]              u_sat;
  logic [DW-1:0]              deg_c;
  bce_pkg::bce_ctl_t          ctl;

  logic [PW-1:0]              a_link [MAX_POINTS+1];
  logic [PW-1:0]              b_link [MAX_POINTS+1];
  logic signed [AW-1:0]       s_link [MAX_POINTS+1][3];

  function automatic logic signed [OW-1:0] round_sat(input logic signed [AW-1:0] acc);
    logic signed [AW-1:0] t;
    logic signed [AW-1:0] q;
    t = acc + bce_pkg::OUT_RND;
    q = t >>> bce_pkg::OUT_SHIFT;
    if (q > bce_pkg::SAT_HI) return bce_pkg::SAT_HI[OW-1:0];
    if (q < bce_pkg::SAT_LO) return bce_pkg::SAT_LO[OW-1:0];
    return q[OW-1:0];
  endfunction

  assign in_ready   = !busy_r;
  assign cfg_ready  = 1'b1;
  assign in_xfer    = in_valid && in_ready;
  assign eval_start = in_xfer && (in_data.cmd == bce_pkg::CMD_EVAL);
  assign ld_point   = in_xfer && (in_data.cmd == bce_pkg::CMD_LOAD);
  assign finish     = busy_r && (cnt_r == CNT_W'(DONE_CNT)) && (!out_valid_r || out_ready);

  assign u_sat = (in_data.param_u > bce_pkg::U_ONE) ? bce_pkg::U_ONE : in_data.param_u;

  always_comb begin
    if (deg_cfg_r == '0) begin
      deg_c = DW'(1);
    end else if (32'(deg_cfg_r) > MAX_POINTS - 1) begin
      deg_c = DW'(MAX_POINTS - 1);
    end else begin
      deg_c = DW'(deg_cfg_r);
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    cnt_nxt       = cnt_r;
    deg_cfg_nxt   = (cfg_valid && cfg_ready) ? cfg_data : deg_cfg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (eval_start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (finish) begin
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
    end else if (busy_r && cnt_r != CNT_W'(DONE_CNT)) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      deg_cfg_r   <= bce_pkg::DEG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      cnt_r       <= cnt_nxt;
      deg_cfg_r   <= deg_cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (eval_start) begin
      u_r   <= u_sat;
      v_r   <= bce_pkg::U_ONE - u_sat;
      deg_r <= deg_c;
    end
    if (finish) begin
      out_data_r <= '{curve_x: round_sat(s_link[MAX_POINTS][0]),
                      curve_y: round_sat(s_link[MAX_POINTS][1]),
                      curve_z: round_sat(s_link[MAX_POINTS][2])};
    end
  end

  assign ctl = '{u: u_r, v: v_r, deg: deg_r, wr: ld_point,
                 wr_idx: in_data.point_index,
                 wr_x: in_data.coord_x, wr_y: in_data.coord_y, wr_z: in_data.coord_z};

  assign a_link[0]          = bce_pkg::POW_ONE;
  assign b_link[MAX_POINTS] = bce_pkg::POW_ONE;
  for (genvar c = 0; c < 3; c++) begin : g_szero
    assign s_link[0][c] = '0;
  end

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    bce_cell #(
      .COORD_BITS (COORD_BITS),
      .IDX        (i)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .a_in  (a_link[i]),
      .b_in  (b_link[i+1]),
      .s_in  (s_link[i]),
      .a_out (a_link[i+1]),
      .b_out (b_link[i]),
      .s_out (s_link[i+1])
    );
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `BCE_ASSERT_NEXT(a_eval_starts_count, eval_start, busy_r && cnt_r == '0, "evaluate did not start the sequencer")
  `BCE_ASSERT_NEXT(a_busy_until_done, busy_r && cnt_r != CNT_W'(DONE_CNT), busy_r, "evaluation ended early")
  `BCE_ASSERT_HOLDS(a_cnt_bound, busy_r, cnt_r <= CNT_W'(DONE_CNT), "sequencer count past end")
  `BCE_ASSERT_HOLDS(a_deg_range, busy_r, deg_r != '0 && 32'(deg_r) <= MAX_POINTS - 1, "degree out of range")
  `BCE_ASSERT_NEXT(a_result_on_finish, finish, out_valid && !busy_r, "finished result not presented")

endmodule
